// File: hw/rtl/lfsm_pkg.sv
// ----------------------------------------------------------------------------
// lfsm_pkg
// Types, widths, codes and reset values shared by the fault monitor modules.
// ----------------------------------------------------------------------------
package lfsm_pkg;

  localparam int unsigned EVENT_DEPTH_DEF = 16;
  localparam int unsigned WHEEL_COUNT_DEF = 4;

  localparam int unsigned CMD_W       = 2;
  localparam int unsigned DT_W        = 16;
  localparam int unsigned MASK_W      = 4;
  localparam int unsigned UNC_W       = 16;
  localparam int unsigned RATE_W      = 16;
  localparam int unsigned SQ_W        = 32;
  localparam int unsigned SOC_W       = 10;
  localparam int unsigned MODE_W      = 3;
  localparam int unsigned EIDX_W      = 4;
  localparam int unsigned FAULT_W     = 4;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned TOTAL_W     = 5;
  localparam int unsigned WHEEL_CNT_W = 4;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam int unsigned IN_TDATA_W  = 104;
  localparam int unsigned IN_PAD_W    = 3;
  localparam int unsigned OUT_TDATA_W = 56;
  localparam int unsigned OUT_PAD_W   = 6;

  // Fault bit positions.
  localparam int unsigned FLT_WHEELS = 0;
  localparam int unsigned FLT_UNCERT = 1;
  localparam int unsigned FLT_RATE   = 2;
  localparam int unsigned FLT_BATT   = 3;

  localparam logic [MODE_W-1:0] MODE_DETUMBLE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SUN      = 3'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_EVAL  = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE      = 3'd0,
    REG_MIN_WHEELS  = 3'd1,
    REG_UNC_TRIGGER = 3'd2,
    REG_UNC_SUSTAIN = 3'd3,
    REG_RATE_SQ     = 3'd4,
    REG_LOW_SOC     = 3'd5
  } cfg_reg_e;

  localparam logic                   RST_ENABLE      = 1'b1;
  localparam logic [WHEEL_CNT_W-1:0] RST_MIN_WHEELS  = 4'd3;
  localparam logic [UNC_W-1:0]       RST_UNC_TRIGGER = 16'd500;
  localparam logic [TIME_W-1:0]      RST_UNC_SUSTAIN = 32'd10000;
  localparam logic [SQ_W-1:0]        RST_RATE_SQ     = 32'd67108864;
  localparam logic [SOC_W-1:0]       RST_LOW_SOC     = 10'd200;

  typedef struct packed {
    logic                   monitor_enable;
    logic [WHEEL_CNT_W-1:0] min_healthy_wheels;
    logic [UNC_W-1:0]       uncertainty_trigger;
    logic [TIME_W-1:0]      uncertainty_sustain_ms;
    logic [SQ_W-1:0]        excess_rate_sq;
    logic [SOC_W-1:0]       low_battery_soc;
  } cfg_t;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic [DT_W-1:0]          dt_ms;
    logic [MASK_W-1:0]        wheel_health_mask;
    logic [UNC_W-1:0]         attitude_uncertainty;
    logic signed [RATE_W-1:0] rate_x;
    logic signed [RATE_W-1:0] rate_y;
    logic signed [RATE_W-1:0] rate_z;
    logic [SOC_W-1:0]         battery_soc;
    logic [MODE_W-1:0]        commanded_mode;
    logic [EIDX_W-1:0]        event_index;
  } item_t;

  typedef struct packed {
    logic [TIME_W-1:0]  time_ms;
    logic [FAULT_W-1:0] flags;
    logic               entering;
  } log_entry_t;

  typedef struct packed {
    logic [TIME_W-1:0]  timer;
    logic [FAULT_W-1:0] detected;
  } eval_t;

  typedef struct packed {
    logic              step;
    logic              wr_en;
    log_entry_t        wr_entry;
    logic              rd_en;
    logic [EIDX_W-1:0] rd_back;
  } log_req_t;

endpackage

// File: hw/rtl/lfsm_fault_eval.sv
// ----------------------------------------------------------------------------
// lfsm_fault_eval
// Fault detection for one evaluate tick: wheel count, sustained uncertainty,
// squared body rate and low battery, plus the next elevated-time value.
// ----------------------------------------------------------------------------
module lfsm_fault_eval import lfsm_pkg::*; #(
  parameter int unsigned WHEEL_COUNT = WHEEL_COUNT_DEF
) (
  input  item_t             item_i,
  input  cfg_t              cfg_i,
  input  logic [TIME_W-1:0] timer_i,
  output eval_t             eval_o
);

  logic [WHEEL_CNT_W-1:0] healthy;
  logic [TIME_W:0]        timer_sum;
  logic [TIME_W-1:0]      timer_next;
  logic signed [SQ_W-1:0] sq_x, sq_y, sq_z;
  logic [SQ_W-1:0]        rate_sq;

  // Mask bits at or above the wheel count are ignored.
  always_comb begin
    healthy = '0;
    for (int b = 0; b < MASK_W; b++) begin
      if (b < WHEEL_COUNT) begin
        healthy = healthy + WHEEL_CNT_W'(item_i.wheel_health_mask[b]);
      end
    end
  end

  assign timer_sum = {1'b0, timer_i} + (TIME_W + 1)'(item_i.dt_ms);

  always_comb begin
    if (item_i.attitude_uncertainty > cfg_i.uncertainty_trigger) begin
      timer_next = timer_sum[TIME_W] ? '1 : timer_sum[TIME_W-1:0];
    end else begin
      timer_next = '0;
    end
  end

  // Each square is at most 2^30, so the sum of three fits in 32 bits.
  assign sq_x    = item_i.rate_x * item_i.rate_x;
  assign sq_y    = item_i.rate_y * item_i.rate_y;
  assign sq_z    = item_i.rate_z * item_i.rate_z;
  assign rate_sq = unsigned'(sq_x) + unsigned'(sq_y) + unsigned'(sq_z);

  always_comb begin
    eval_o.timer                = timer_next;
    eval_o.detected             = '0;
    eval_o.detected[FLT_WHEELS] = healthy < cfg_i.min_healthy_wheels;
    eval_o.detected[FLT_UNCERT] = timer_next > cfg_i.uncertainty_sustain_ms;
    eval_o.detected[FLT_RATE]   = rate_sq > cfg_i.excess_rate_sq;
    eval_o.detected[FLT_BATT]   = item_i.battery_soc < cfg_i.low_battery_soc;
  end

endmodule

// File: hw/rtl/lfsm_event_log.sv
// ----------------------------------------------------------------------------
// lfsm_event_log
// Ring store of fault events with per-entry valid bits, a write pointer and
// a saturating event count. Reads count back from the newest entry.
// ----------------------------------------------------------------------------
module lfsm_event_log import lfsm_pkg::*; #(
  parameter int unsigned EVENT_DEPTH = EVENT_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  log_req_t           req_i,
  output log_entry_t         rd_entry_o,
  output logic [TOTAL_W-1:0] total_o
);

  localparam int unsigned IW = $clog2(EVENT_DEPTH);
  localparam int unsigned CW = $clog2(EVENT_DEPTH + 1);
  localparam int unsigned BACK_N = 1 << EIDX_W;

  log_entry_t           mem [EVENT_DEPTH];
  logic [EVENT_DEPTH-1:0] valid_q;
  logic [IW-1:0]        wp_q, wp_d;
  logic [CW-1:0]        count_q, count_d;
  log_entry_t           rd_data_q;
  logic                 rd_vld_q;
  logic [IW-1:0]        back_tbl [BACK_N];
  logic [IW-1:0]        back;
  logic [IW:0]          slot_sum;
  logic [IW-1:0]        raddr;

  // The event index taken modulo the depth, worked out at elaboration.
  for (genvar g = 0; g < BACK_N; g++) begin : g_back
    assign back_tbl[g] = IW'(g % EVENT_DEPTH);
  end

  assign back = back_tbl[req_i.rd_back];

  // Newest entry sits one below the write pointer; sum stays below 2*depth.
  assign slot_sum = {1'b0, wp_q} + (IW + 1)'(EVENT_DEPTH - 1) - {1'b0, back};
  assign raddr = (slot_sum >= (IW + 1)'(EVENT_DEPTH)) ?
                 IW'(slot_sum - (IW + 1)'(EVENT_DEPTH)) : IW'(slot_sum);

  assign wp_d = !req_i.wr_en ? wp_q :
                (wp_q == IW'(EVENT_DEPTH - 1)) ? '0 : wp_q + 1'b1;
  assign count_d = (req_i.wr_en && count_q != CW'(EVENT_DEPTH)) ?
                   count_q + 1'b1 : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q     <= '0;
      count_q  <= '0;
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      wp_q    <= wp_d;
      count_q <= count_d;
      if (req_i.wr_en) begin
        valid_q[wp_q] <= 1'b1;
      end
      if (req_i.step) begin
        rd_vld_q <= req_i.rd_en && valid_q[raddr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[wp_q] <= req_i.wr_entry;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[raddr];
    end
  end

  // Entries never written read as zero, as does any non-read item.
  assign rd_entry_o = rd_vld_q ? rd_data_q : '0;
  assign total_o    = TOTAL_W'(count_d);

endmodule

// File: hw/rtl/latched_fault_safe_mode_monitor.sv
// ----------------------------------------------------------------------------
// latched_fault_safe_mode_monitor
// Latched fault monitor with safe-mode override and a ring event log.
// ----------------------------------------------------------------------------
// Result path: an accepted item waits in the input register, then one
// evaluation pass feeds the result register and the log read.
// Throughput: one item per cycle while the output is not stalled; the single evaluation stage sets the rate.
// Reset: config registers return to defaults, clock, timer and latches clear,
// and the log's valid bits clear at once, so the block is ready immediately.
module latched_fault_safe_mode_monitor import lfsm_pkg::*; #(
  parameter int unsigned EVENT_DEPTH = EVENT_DEPTH_DEF,
  parameter int unsigned WHEEL_COUNT = WHEEL_COUNT_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // dt_ms, wheel_health_mask, attitude_uncertainty, rate_x, rate_y, rate_z,
  // battery_soc, commanded_mode, event_index, zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // cmd
  input  logic [CMD_W-1:0]       s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // pointing_mode, hold flag, active_faults, event_time_ms, event_flags,
  // event_entering, event_total, zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  cfg_t               cfg_q;
  logic               in_vld_q;
  item_t              item_q, item_in;
  logic               out_vld_q;
  logic               advance, fire;
  eval_t              eval;
  logic [TIME_W-1:0]  mission_q, mission_d;
  logic [TIME_W-1:0]  timer_q, timer_d;
  logic [FAULT_W-1:0] latched_q, latched_d;
  logic [FAULT_W-1:0] fresh;
  logic               hold_d, hold_q;
  logic [MODE_W-1:0]  mode_d, mode_q;
  logic [FAULT_W-1:0] faults_q;
  logic [TOTAL_W-1:0] total, total_q;
  log_req_t           log_req;
  log_entry_t         rd_entry;

  // Configuration.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.monitor_enable         <= RST_ENABLE;
      cfg_q.min_healthy_wheels     <= RST_MIN_WHEELS;
      cfg_q.uncertainty_trigger    <= RST_UNC_TRIGGER;
      cfg_q.uncertainty_sustain_ms <= RST_UNC_SUSTAIN;
      cfg_q.excess_rate_sq         <= RST_RATE_SQ;
      cfg_q.low_battery_soc        <= RST_LOW_SOC;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_ENABLE:      cfg_q.monitor_enable         <= cfg_data_i[0];
        REG_MIN_WHEELS:  cfg_q.min_healthy_wheels     <= cfg_data_i[WHEEL_CNT_W-1:0];
        REG_UNC_TRIGGER: cfg_q.uncertainty_trigger    <= cfg_data_i[UNC_W-1:0];
        REG_UNC_SUSTAIN: cfg_q.uncertainty_sustain_ms <= cfg_data_i[TIME_W-1:0];
        REG_RATE_SQ:     cfg_q.excess_rate_sq         <= cfg_data_i[SQ_W-1:0];
        REG_LOW_SOC:     cfg_q.low_battery_soc        <= cfg_data_i[SOC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input register. It refills in the same cycle that its item moves on.
  assign advance       = !out_vld_q || m_axis_tready;
  assign fire          = in_vld_q && advance;
  assign s_axis_tready = !in_vld_q || advance;

  always_comb begin
    item_in.cmd                  = s_axis_tuser;
    item_in.dt_ms                = s_axis_tdata[15:0];
    item_in.wheel_health_mask    = s_axis_tdata[19:16];
    item_in.attitude_uncertainty = s_axis_tdata[35:20];
    item_in.rate_x               = s_axis_tdata[51:36];
    item_in.rate_y               = s_axis_tdata[67:52];
    item_in.rate_z               = s_axis_tdata[83:68];
    item_in.battery_soc          = s_axis_tdata[93:84];
    item_in.commanded_mode       = s_axis_tdata[96:94];
    item_in.event_index          = s_axis_tdata[100:97];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q <= item_in;
    end
  end

  lfsm_fault_eval #(
    .WHEEL_COUNT(WHEEL_COUNT)
  ) u_eval (
    .item_i (item_q),
    .cfg_i  (cfg_q),
    .timer_i(timer_q),
    .eval_o (eval)
  );

  assign fresh = eval.detected & ~latched_q;

  always_comb begin
    mission_d       = mission_q;
    timer_d         = timer_q;
    latched_d       = latched_q;
    log_req         = '0;
    log_req.step    = fire;
    log_req.rd_back = item_q.event_index;
    if (fire) begin
      unique case (cmd_e'(item_q.cmd))
        CMD_EVAL: begin
          mission_d = mission_q + TIME_W'(item_q.dt_ms);
          timer_d   = eval.timer;
          latched_d = latched_q | eval.detected;
          // Only faults that were not already latched open a new event.
          if (fresh != '0) begin
            log_req.wr_en             = 1'b1;
            log_req.wr_entry.time_ms  = mission_d;
            log_req.wr_entry.flags    = fresh;
            log_req.wr_entry.entering = 1'b1;
          end
        end
        CMD_CLEAR: begin
          if (latched_q != '0) begin
            log_req.wr_en             = 1'b1;
            log_req.wr_entry.time_ms  = mission_q;
            log_req.wr_entry.flags    = latched_q;
            log_req.wr_entry.entering = 1'b0;
          end
          latched_d = '0;
          timer_d   = '0;
        end
        CMD_READ: begin
          log_req.rd_en = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    hold_d = cfg_q.monitor_enable && (latched_d != '0);
    if (hold_d) begin
      mode_d = latched_d[FLT_RATE] ? MODE_DETUMBLE : MODE_SUN;
    end else begin
      mode_d = item_q.commanded_mode;
    end
  end

  lfsm_event_log #(
    .EVENT_DEPTH(EVENT_DEPTH)
  ) u_log (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (log_req),
    .rd_entry_o(rd_entry),
    .total_o   (total)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mission_q <= '0;
      timer_q   <= '0;
      latched_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      mission_q <= mission_d;
      timer_q   <= timer_d;
      latched_q <= latched_d;
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      mode_q   <= mode_d;
      hold_q   <= hold_d;
      faults_q <= latched_d;
      total_q  <= total;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {OUT_PAD_W'(0), total_q, rd_entry.entering, rd_entry.flags,
                          rd_entry.time_ms, faults_q, hold_q, mode_q};

endmodule
